// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define DMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dms_pkg.sv -----
// shared constants, types and functions for the coordinate text parser
package dms_pkg;

    // default parameter values
    localparam int FRAC_DIGITS_DEF = 4;
    localparam int DEGREE_BITS_DEF = 16;

    // result word
    localparam int OUT_W   = 43;
    localparam int TDATA_W = 48;
    localparam int TUSER_W = 1;
    localparam int CHAR_W  = 8;

    // unit conversion
    localparam int SEC_PER_DEG = 3600;
    localparam int SEC_PER_MIN = 60;

    // config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_AXIS_MODE = 1'b0;

    // status handed from the parser to the scaling pipeline
    typedef struct packed {
        logic ok;
        logic negate;
    } dms_flags_t;

    // ten to the power n, evaluated at elaboration
    function automatic longint pow10(input int n);
        longint v;
        v = 1;
        for (int i = 0; i < n; i++) begin
            v = v * 10;
        end
        return v;
    endfunction

endpackage

// ----- src/dms_parse.sv -----
// character-by-character parser: phase tracking and field accumulators
module dms_parse #(
    parameter int FRAC_DIGITS = dms_pkg::FRAC_DIGITS_DEF,
    parameter int DEGREE_BITS = dms_pkg::DEGREE_BITS_DEF,
    parameter int FRAC_W      = 14,
    parameter int CNT_W       = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      char_take,
    input  logic [dms_pkg::CHAR_W-1:0] char_in,
    input  logic                      char_last,
    input  logic                      axis_mode,
    output logic                      tok_valid,
    output logic [DEGREE_BITS-1:0]    tok_deg,
    output logic [6:0]                tok_min,
    output logic [6:0]                tok_sec,
    output logic [FRAC_W-1:0]         tok_frac,
    output logic [CNT_W-1:0]          tok_cnt,
    output dms_pkg::dms_flags_t       tok_flags
);

    // parse phases
    localparam logic [3:0] PH_DEG_PRE    = 4'd0;
    localparam logic [3:0] PH_SEC_DIG    = 4'd8;
    localparam logic [3:0] PH_DEG_SIGN   = 4'd1;
    localparam logic [3:0] PH_DEG_DIG    = 4'd2;
    localparam logic [3:0] PH_MIN_PRE    = 4'd3;
    localparam logic [3:0] PH_MIN_SIGN   = 4'd4;
    localparam logic [3:0] PH_MIN_DIG    = 4'd5;
    localparam logic [3:0] PH_SEC_PRE    = 4'd6;
    localparam logic [3:0] PH_SEC_SIGN   = 4'd7;
    localparam logic [3:0] PH_FRAC_FIRST = 4'd9;
    localparam logic [3:0] PH_FRAC_DIG   = 4'd10;
    localparam logic [3:0] PH_LETTER     = 4'd11;
    localparam logic [3:0] PH_DONE       = 4'd12;

    // field and sub-step within a whole-number phase
    localparam logic [1:0] FLD_DEG  = 2'd0;
    localparam logic [1:0] FLD_MIN  = 2'd1;
    localparam logic [1:0] FLD_SEC  = 2'd2;
    localparam logic [1:0] SUB_PRE  = 2'd0;
    localparam logic [1:0] SUB_SIGN = 2'd1;
    localparam logic [1:0] SUB_DIG  = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_N  = 8'h6e;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_W  = 8'h77;

    localparam logic [6:0] SIXTY = 7'd60;
    localparam int         DW    = DEGREE_BITS + 4;

    logic [3:0]             phase_reg, phase_next;
    logic [DEGREE_BITS-1:0] deg_reg, deg_next;
    logic [6:0]             min_reg, min_next;
    logic [6:0]             sec_reg, sec_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   minus_reg, minus_next;
    logic                   nonzero_reg, nonzero_next;
    logic                   err_reg, err_next;
    logic                   neg_reg, neg_next;

    logic [7:0]    c;
    logic [3:0]    d;
    logic          is_dig;
    logic          is_sp;
    logic [1:0]    fld;
    logic [1:0]    sub;
    logic [DW-1:0] deg_try;
    logic [9:0]    min_try;
    logic [9:0]    sec_try;
    logic          dig_fail;
    logic [7:0]    lc;
    logic          let_neg;
    logic          let_pos;
    logic          take_dig;
    logic          take_let;
    logic          do_fail;

    // character classes and digit trial values
    always_comb begin
        c       = char_in;
        d       = 4'(c - CH_ZERO);
        is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sp   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        deg_try = DW'(deg_reg) * DW'(10) + DW'(d);
        min_try = 10'(min_reg) * 10'd10 + 10'(d);
        sec_try = 10'(sec_reg) * 10'd10 + 10'(d);
        lc      = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CH_CASE) : c;
        let_neg = axis_mode ? (lc == CH_LO_E) : (lc == CH_LO_S);
        let_pos = axis_mode ? (lc == CH_LO_W) : (lc == CH_LO_N);
    end

    // field and sub-step of the current phase
    always_comb begin
        unique case (phase_reg)
            PH_DEG_PRE:  begin fld = FLD_DEG; sub = SUB_PRE;  end
            PH_DEG_SIGN: begin fld = FLD_DEG; sub = SUB_SIGN; end
            PH_DEG_DIG:  begin fld = FLD_DEG; sub = SUB_DIG;  end
            PH_MIN_PRE:  begin fld = FLD_MIN; sub = SUB_PRE;  end
            PH_MIN_SIGN: begin fld = FLD_MIN; sub = SUB_SIGN; end
            PH_MIN_DIG:  begin fld = FLD_MIN; sub = SUB_DIG;  end
            PH_SEC_PRE:  begin fld = FLD_SEC; sub = SUB_PRE;  end
            PH_SEC_SIGN: begin fld = FLD_SEC; sub = SUB_SIGN; end
            PH_SEC_DIG:  begin fld = FLD_SEC; sub = SUB_DIG;  end
            default:     begin fld = FLD_DEG; sub = SUB_PRE;  end
        endcase
    end

    // overflow of the field that takes the digit
    always_comb begin
        unique case (fld)
            FLD_DEG: dig_fail = (deg_try[DW-1:DEGREE_BITS] != '0);
            FLD_MIN: dig_fail = (min_try >= 10'(SIXTY));
            default: dig_fail = (sec_try >= 10'(SIXTY));
        endcase
    end

    // next parser state for one character
    always_comb begin
        phase_next   = phase_reg;
        deg_next     = deg_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        minus_next   = minus_reg;
        nonzero_next = nonzero_reg;
        err_next     = err_reg;
        neg_next     = neg_reg;
        take_dig     = 1'b0;
        take_let     = 1'b0;
        do_fail      = 1'b0;

        if (phase_reg == PH_DONE) begin
            // text finished, ignore the rest
        end else if (c == CH_NUL) begin
            do_fail = 1'b1;
        end else if (phase_reg <= PH_SEC_DIG) begin
            unique case (sub)
                SUB_PRE: begin
                    if (is_sp) begin
                        // skip leading whitespace
                    end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                        minus_next = (c == CH_MINUS);
                        phase_next = phase_reg + 4'd1;
                    end else if (is_dig) begin
                        phase_next = phase_reg + 4'd2;
                        take_dig   = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                SUB_SIGN: begin
                    if (is_dig) begin
                        phase_next = phase_reg + 4'd1;
                        take_dig   = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                default: begin
                    if (is_dig) begin
                        take_dig = 1'b1;
                    end else if (minus_reg && nonzero_reg) begin
                        do_fail = 1'b1;
                    end else begin
                        minus_next   = 1'b0;
                        nonzero_next = 1'b0;
                        if (c == CH_DOT) begin
                            phase_next = (fld == FLD_SEC) ? PH_FRAC_FIRST
                                                          : phase_reg + 4'd1;
                        end else if (is_sp) begin
                            phase_next = PH_LETTER;
                        end else begin
                            take_let = 1'b1;
                        end
                    end
                end
            endcase
        end else if ((phase_reg == PH_FRAC_FIRST) || (phase_reg == PH_FRAC_DIG)) begin
            if (is_dig) begin
                if (cnt_reg < CNT_W'(FRAC_DIGITS)) begin
                    frac_next = FRAC_W'((FRAC_W + 4)'(frac_reg) * (FRAC_W + 4)'(10)
                                        + (FRAC_W + 4)'(d));
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                phase_next = PH_FRAC_DIG;
            end else if (phase_reg == PH_FRAC_FIRST) begin
                do_fail = 1'b1;
            end else if (is_sp) begin
                phase_next = PH_LETTER;
            end else begin
                take_let = 1'b1;
            end
        end else if (phase_reg == PH_LETTER) begin
            take_let = !is_sp;
        end else begin
            do_fail = 1'b1;
        end

        // digit into the current whole-number field
        if (take_dig) begin
            nonzero_next = nonzero_reg || (d != 4'd0);
            if (dig_fail) begin
                do_fail = 1'b1;
            end else begin
                unique case (fld)
                    FLD_DEG: deg_next = deg_try[DEGREE_BITS-1:0];
                    FLD_MIN: min_next = min_try[6:0];
                    default: sec_next = sec_try[6:0];
                endcase
            end
        end

        // hemisphere letter
        if (take_let) begin
            if (let_neg) begin
                neg_next   = 1'b1;
                phase_next = PH_DONE;
            end else if (let_pos) begin
                phase_next = PH_DONE;
            end else begin
                do_fail = 1'b1;
            end
        end

        if (do_fail) begin
            err_next   = 1'b1;
            phase_next = PH_DONE;
        end
    end

    // state registers, cleared at reset and after the last character of a text
    always_ff @(posedge aclk) begin
        if (!aresetn || (char_take && char_last)) begin
            phase_reg   <= PH_DEG_PRE;
            deg_reg     <= '0;
            min_reg     <= '0;
            sec_reg     <= '0;
            frac_reg    <= '0;
            cnt_reg     <= '0;
            minus_reg   <= 1'b0;
            nonzero_reg <= 1'b0;
            err_reg     <= 1'b0;
            neg_reg     <= 1'b0;
        end else if (char_take) begin
            phase_reg   <= phase_next;
            deg_reg     <= deg_next;
            min_reg     <= min_next;
            sec_reg     <= sec_next;
            frac_reg    <= frac_next;
            cnt_reg     <= cnt_next;
            minus_reg   <= minus_next;
            nonzero_reg <= nonzero_next;
            err_reg     <= err_next;
            neg_reg     <= neg_next;
        end
    end

    // snapshot of the finished text for the scaling pipeline
    assign tok_valid        = char_take && char_last;
    assign tok_deg          = deg_next;
    assign tok_min          = min_next;
    assign tok_sec          = sec_next;
    assign tok_frac         = frac_next;
    assign tok_cnt          = cnt_next;
    assign tok_flags.ok     = (phase_next == PH_DONE) && !err_next;
    assign tok_flags.negate = neg_next;

endmodule

// ----- src/dms_scale.sv -----
// pipeline that turns parsed fields into signed scaled arc seconds
module dms_scale #(
    parameter int FRAC_DIGITS = dms_pkg::FRAC_DIGITS_DEF,
    parameter int DEGREE_BITS = dms_pkg::DEGREE_BITS_DEF,
    parameter int FRAC_W      = 14,
    parameter int CNT_W       = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        tok_valid,
    output logic                        tok_ready,
    input  logic [DEGREE_BITS-1:0]      tok_deg,
    input  logic [6:0]                  tok_min,
    input  logic [6:0]                  tok_sec,
    input  logic [FRAC_W-1:0]           tok_frac,
    input  logic [CNT_W-1:0]            tok_cnt,
    input  dms_pkg::dms_flags_t         tok_flags,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dms_pkg::TDATA_W-1:0] m_tdata,
    output logic [dms_pkg::TUSER_W-1:0] m_tuser
);

    localparam longint SCALE   = dms_pkg::pow10(FRAC_DIGITS);
    localparam int     PW      = $clog2(SCALE + 1);
    localparam int     WHOLE_W = DEGREE_BITS + 12;
    localparam int     HALF    = WHOLE_W / 2;
    localparam int     LO_W    = HALF + PW;
    localparam int     HI_W    = WHOLE_W - HALF + PW;
    localparam int     FM_W    = FRAC_W + PW;
    localparam int     OUT_W   = dms_pkg::OUT_W;
    localparam int     TAB_N   = 1 << CNT_W;

    // scale for the fraction by digit count
    logic [PW-1:0] scale_tab [TAB_N];

    for (genvar i = 0; i < TAB_N; i++) begin : g_tab
        if (i <= FRAC_DIGITS) begin : g_used
            assign scale_tab[i] = PW'(dms_pkg::pow10(FRAC_DIGITS - i));
        end else begin : g_unused
            assign scale_tab[i] = '0;
        end
    end

    logic                v1_reg, v2_reg, v3_reg, vo_reg;
    logic                rdy1, rdy2, rdy3, rdyo;
    logic [WHOLE_W-1:0]  whole1_reg;
    logic [FRAC_W-1:0]   fsc1_reg, fsc2_reg;
    dms_pkg::dms_flags_t fl1_reg, fl2_reg, fl3_reg;
    logic [LO_W-1:0]     lo2_reg;
    logic [HI_W-1:0]     hi2_reg;
    logic [OUT_W-1:0]    sum3_reg;
    logic [OUT_W-1:0]    data_reg;
    logic                ok_reg;

    // ready chain, each stage loads when empty or draining
    assign rdyo      = !vo_reg || m_tready;
    assign rdy3      = !v3_reg || rdyo;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign tok_ready = rdy1;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= tok_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    // stage 1: whole seconds and scaled fraction
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            whole1_reg <= WHOLE_W'(tok_deg) * WHOLE_W'(dms_pkg::SEC_PER_DEG)
                        + WHOLE_W'(tok_min) * WHOLE_W'(dms_pkg::SEC_PER_MIN)
                        + WHOLE_W'(tok_sec);
            fsc1_reg   <= FRAC_W'(FM_W'(tok_frac) * FM_W'(scale_tab[tok_cnt]));
            fl1_reg    <= tok_flags;
        end
    end

    // stage 2: whole seconds times the fraction scale, in two halves
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            lo2_reg  <= LO_W'(whole1_reg[HALF-1:0]) * LO_W'(SCALE);
            hi2_reg  <= HI_W'(whole1_reg[WHOLE_W-1:HALF]) * HI_W'(SCALE);
            fsc2_reg <= fsc1_reg;
            fl2_reg  <= fl1_reg;
        end
    end

    // stage 3: combine partial products and fraction
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sum3_reg <= (OUT_W'(hi2_reg) << HALF) + OUT_W'(lo2_reg) + OUT_W'(fsc2_reg);
            fl3_reg  <= fl2_reg;
        end
    end

    // output register: sign and validity
    always_ff @(posedge aclk) begin
        if (rdyo) begin
            ok_reg <= fl3_reg.ok;
            if (!fl3_reg.ok) begin
                data_reg <= '0;
            end else if (fl3_reg.negate) begin
                data_reg <= OUT_W'(0) - sum3_reg;
            end else begin
                data_reg <= sum3_reg;
            end
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = dms_pkg::TDATA_W'(data_reg);
    assign m_tuser  = dms_pkg::TUSER_W'(ok_reg);

endmodule

// ----- src/dms_coordinate_text_parser.sv -----
// top level of the degrees-minutes-seconds coordinate text parser
//
// Characters arrive one per transfer on the s_ side, with s_tlast on the final
// character of a text; the block accepts one character every cycle while
// s_tready is high. Each character is parsed as it is taken into small
// accumulators (degrees, minutes, seconds, fraction digits). The transfer
// marked last launches one result through a four-stage pipeline (whole seconds
// and fraction scale, split multiply by ten to FRAC_DIGITS, final sum, sign
// and output register). m_tuser[0] is 1 for a valid coordinate; m_tdata holds
// the signed arc seconds times ten to FRAC_DIGITS, zero when invalid. s_tready
// drops only while all four pipeline stages hold results and m_tready is low.
// axis_mode (APB address 0, bit 0) selects s/n latitude (0) or e/w longitude
// (1) letters.
module dms_coordinate_text_parser #(
    parameter int FRAC_DIGITS = dms_pkg::FRAC_DIGITS_DEF,
    parameter int DEGREE_BITS = dms_pkg::DEGREE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input characters
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] text_char
    input  logic                           s_tlast,   // is_last
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dms_pkg::TDATA_W-1:0]    m_tdata,   // [42:0] scaled_seconds, rest zero
    output logic [dms_pkg::TUSER_W-1:0]    m_tuser,   // [0] valid_res
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dms_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam longint SCALE  = dms_pkg::pow10(FRAC_DIGITS);
    localparam int     FRAC_W = $clog2(SCALE);
    localparam int     CNT_W  = $clog2(FRAC_DIGITS + 1);

    logic                   axis_mode_reg;
    logic                   cfg_sel;
    logic                   char_take;
    logic                   tok_valid;
    logic                   tok_ready;
    logic [DEGREE_BITS-1:0] tok_deg;
    logic [6:0]             tok_min;
    logic [6:0]             tok_sec;
    logic [FRAC_W-1:0]      tok_frac;
    logic [CNT_W-1:0]       tok_cnt;
    dms_pkg::dms_flags_t    tok_flags;

    // config register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[dms_pkg::APB_ADDR_W-1:2] == dms_pkg::REG_AXIS_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            axis_mode_reg <= pwdata[0];
        end
    end

    assign prdata = cfg_sel ? dms_pkg::APB_DATA_W'(axis_mode_reg) : '0;

    // character transfer
    assign s_tready  = tok_ready;
    assign char_take = s_tvalid && s_tready;

    dms_parse #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .DEGREE_BITS (DEGREE_BITS),
        .FRAC_W      (FRAC_W),
        .CNT_W       (CNT_W)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_take (char_take),
        .char_in   (s_tdata),
        .char_last (s_tlast),
        .axis_mode (axis_mode_reg),
        .tok_valid (tok_valid),
        .tok_deg   (tok_deg),
        .tok_min   (tok_min),
        .tok_sec   (tok_sec),
        .tok_frac  (tok_frac),
        .tok_cnt   (tok_cnt),
        .tok_flags (tok_flags)
    );

    dms_scale #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .DEGREE_BITS (DEGREE_BITS),
        .FRAC_W      (FRAC_W),
        .CNT_W       (CNT_W)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_deg   (tok_deg),
        .tok_min   (tok_min),
        .tok_sec   (tok_sec),
        .tok_frac  (tok_frac),
        .tok_cnt   (tok_cnt),
        .tok_flags (tok_flags),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- src/dms_checker.sv -----
// port-level checks on the parser's result channel, bound to the top level
`include "assert_macros.svh"

module dms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dms_pkg::TDATA_W-1:0]    m_tdata,
    input logic [dms_pkg::TUSER_W-1:0]    m_tuser
);

    // no result right after reset
    `DMS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a stalled transfer keeps its result
    `DMS_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // an invalid coordinate carries zero
    `DMS_ASSERT(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "invalid result not zero")

    // padding above the value stays clear
    `DMS_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[dms_pkg::TDATA_W-1:dms_pkg::OUT_W] == '0, "padding bits set")

endmodule

bind dms_coordinate_text_parser dms_checker u_dms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
